// ===== rtl/tbp_pkg.sv =====
`default_nettype none
package tbp_pkg;

	// default table geometry
	localparam int unsigned SEL_ENTRIES_DEF = 4096;
	localparam int unsigned HIST_BITS_DEF   = 12;

	// 2-bit saturating counters
	localparam int unsigned CTR_W   = 2;
	localparam logic [1:0]  CTR_INIT = 2'd1;
	localparam logic [1:0]  CTR_MAX  = 2'd3;
	localparam logic [1:0]  CTR_MIN  = 2'd0;

	// context word layout: {bimodal_pred, gshare_pred, gshare index}
	localparam int unsigned CTX_IDX_W = 12;
	localparam int unsigned CTX_W     = 14;

	// stream payload widths
	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		ACT_PREDICT = 2'd0,
		ACT_UPDATE  = 2'd1,
		ACT_RECOVER = 2'd2
	} action_t;

	// saturating increment / decrement
	function automatic logic [1:0] ctr_train(input logic [1:0] ctr, input logic up);
		logic [1:0] res;
		res = ctr;
		if (up) begin
			if (ctr != CTR_MAX) res = ctr + 2'd1;
		end else begin
			if (ctr != CTR_MIN) res = ctr - 2'd1;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tbp_ram.sv =====
`default_nettype none
module tbp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/tournament_branch_predictor.sv =====
`default_nettype none
// Tournament branch predictor (bimodal + gshare + chooser, 2-bit counters).
// Takes one transaction per clock: the table read is launched as the item is
// accepted, all counter selection, training and history logic sits between
// the table read registers and the result register, so a prediction passes
// both registers before reaching the master side. While a prediction waits on
// a stalled master side, the slave side is held off until it leaves. Update
// and recover items produce no output transaction. After reset the block
// sweeps all max(SELECT_TABLE_ENTRIES, 2**HISTORY_BITS) entries (4096 by
// default) back to weakly-not-taken, one entry per cycle, holding s_axis_tready
// low until the sweep ends. SELECT_TABLE_ENTRIES must be a power of two.
module tournament_branch_predictor #(
	parameter int unsigned SELECT_TABLE_ENTRIES = tbp_pkg::SEL_ENTRIES_DEF,
	parameter int unsigned HISTORY_BITS         = tbp_pkg::HIST_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	// pc[31:0], imm[63:32], context_req[77:64], outcome[78], zero pad
	input  wire logic [tbp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// action[1:0]
	input  wire logic [tbp_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// pred_taken[0], pred_target[32:1], pred_context[46:33], zero pad
	output      logic [tbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	import tbp_pkg::*;

	localparam int unsigned PAT_ENTRIES = 2 ** HISTORY_BITS;
	localparam int unsigned SEL_AW      = $clog2(SELECT_TABLE_ENTRIES);
	localparam int unsigned HB          = HISTORY_BITS;
	localparam int unsigned CLR_DEPTH   = (SELECT_TABLE_ENTRIES > PAT_ENTRIES) ?
	                                      SELECT_TABLE_ENTRIES : PAT_ENTRIES;
	localparam int unsigned CLR_AW      = $clog2(CLR_DEPTH);

	// input field unpack
	logic [31:0]      in_pc;
	logic [31:0]      in_imm;
	logic [CTX_W-1:0] in_ctx;
	logic             in_actual;
	action_t          in_act;

	assign in_pc     = s_axis_tdata[31:0];
	assign in_imm    = s_axis_tdata[63:32];
	assign in_ctx    = s_axis_tdata[77:64];
	assign in_actual = s_axis_tdata[78];
	assign in_act    = action_t'(s_axis_tuser);

	// control state
	logic              clearing_q;
	logic [CLR_AW-1:0] clr_addr_q;
	logic [HB-1:0]     spec_hist_q;
	logic [HB-1:0]     commit_hist_q;
	logic              out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// stage 1 (table read data lands here)
	logic              valid_s1;
	action_t           act_s1;
	logic [31:0]       pc_s1;
	logic [31:0]       imm_s1;
	logic              ctx_bim_s1;
	logic              ctx_gsh_s1;
	logic              actual_s1;
	logic [SEL_AW-1:0] sel_s1;
	logic [HB-1:0]     pidx_s1;

	// write forwarding: write done on the edge the stage-1 item was read
	logic              fwd_vld_q;
	logic [SEL_AW-1:0] fwd_sel_q;
	logic [HB-1:0]     fwd_pidx_q;
	logic [1:0]        fwd_bim_q;
	logic [1:0]        fwd_cho_q;
	logic [1:0]        fwd_pat_q;

	logic       s1_adv, in_fire, upd_fire, pred_fire;
	logic [1:0] bim_rd, cho_rd, pat_rd;
	logic [1:0] bim_ctr, cho_ctr, pat_ctr;
	logic       bpred, gpred, taken;
	logic [HB-1:0] spec_next;

	// handshake
	assign s1_adv = valid_s1 &&
	                !(act_s1 == ACT_PREDICT && out_vld_q && !m_axis_tready);
	assign s_axis_tready = !clearing_q && (!valid_s1 || s1_adv);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign upd_fire  = s1_adv && act_s1 == ACT_UPDATE;
	assign pred_fire = s1_adv && act_s1 == ACT_PREDICT;

	// counters with forwarding of the previous write
	assign bim_ctr = (fwd_vld_q && fwd_sel_q == sel_s1)   ? fwd_bim_q : bim_rd;
	assign cho_ctr = (fwd_vld_q && fwd_sel_q == sel_s1)   ? fwd_cho_q : cho_rd;
	assign pat_ctr = (fwd_vld_q && fwd_pidx_q == pidx_s1) ? fwd_pat_q : pat_rd;

	assign bpred = bim_ctr[1];
	assign gpred = pat_ctr[1];
	assign taken = cho_ctr[1] ? bpred : gpred;

	// speculative history as seen by the item accepted this cycle
	always_comb begin
		spec_next = spec_hist_q;
		if (s1_adv) begin
			case (act_s1)
				ACT_PREDICT: spec_next = {spec_hist_q[HB-2:0], taken};
				ACT_RECOVER: spec_next = commit_hist_q;
				default:     spec_next = spec_hist_q;
			endcase
		end
	end

	// read addresses for the incoming item
	logic [SEL_AW-1:0]        rd_sel;
	logic [HB-1:0]            rd_pidx;
	logic [HB+CTX_IDX_W-1:0]  ctx_idx_ext;

	assign rd_sel      = in_pc[SEL_AW+1:2];
	assign ctx_idx_ext = {{HB{1'b0}}, in_ctx[CTX_IDX_W-1:0]};
	always_comb begin
		case (in_act)
			ACT_UPDATE: rd_pidx = ctx_idx_ext[HB-1:0];
			default:    rd_pidx = in_pc[HB+1:2] ^ spec_next;
		endcase
	end

	// training values
	logic [1:0] bim_new, pat_new, cho_new;
	assign bim_new = ctr_train(bim_ctr, actual_s1);
	assign pat_new = ctr_train(pat_ctr, actual_s1);
	always_comb begin
		cho_new = cho_ctr;
		if (ctx_gsh_s1 != actual_s1 && ctx_bim_s1 == actual_s1)
			cho_new = ctr_train(cho_ctr, 1'b1);
		else if (ctx_gsh_s1 == actual_s1 && ctx_bim_s1 != actual_s1)
			cho_new = ctr_train(cho_ctr, 1'b0);
	end

	// table write ports, shared with the reset sweep
	logic              tbl_we;
	logic [SEL_AW-1:0] wr_sel;
	logic [HB-1:0]     wr_pidx;
	logic [CLR_AW+SEL_AW+HB-1:0] clr_ext;
	logic [1:0]        wr_bim, wr_cho, wr_pat;

	assign tbl_we  = clearing_q || upd_fire;
	assign clr_ext = {{(SEL_AW+HB){1'b0}}, clr_addr_q};
	assign wr_sel  = clearing_q ? clr_ext[SEL_AW-1:0] : sel_s1;
	assign wr_pidx = clearing_q ? clr_ext[HB-1:0] : pidx_s1;
	assign wr_bim  = clearing_q ? CTR_INIT : bim_new;
	assign wr_cho  = clearing_q ? CTR_INIT : cho_new;
	assign wr_pat  = clearing_q ? CTR_INIT : pat_new;

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(SELECT_TABLE_ENTRIES)) u_bim_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_sel), .wdata(wr_bim),
		.re(in_fire), .raddr(rd_sel), .rdata(bim_rd)
	);

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(SELECT_TABLE_ENTRIES)) u_cho_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_sel), .wdata(wr_cho),
		.re(in_fire), .raddr(rd_sel), .rdata(cho_rd)
	);

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(PAT_ENTRIES)) u_pat_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_pidx), .wdata(wr_pat),
		.re(in_fire), .raddr(rd_pidx), .rdata(pat_rd)
	);

	// reset sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CLR_AW'(CLR_DEPTH - 1)) clearing_q <= 1'b0;
		end
	end

	// stage 1 control and histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			fwd_vld_q     <= 1'b0;
			spec_hist_q   <= '0;
			commit_hist_q <= '0;
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (in_fire) fwd_vld_q <= upd_fire;
			spec_hist_q <= spec_next;
			if (upd_fire) commit_hist_q <= {commit_hist_q[HB-2:0], actual_s1};
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1     <= in_act;
			pc_s1      <= in_pc;
			imm_s1     <= in_imm;
			ctx_bim_s1 <= in_ctx[CTX_W-1];
			ctx_gsh_s1 <= in_ctx[CTX_W-2];
			actual_s1  <= in_actual;
			sel_s1     <= rd_sel;
			pidx_s1    <= rd_pidx;
			fwd_sel_q  <= sel_s1;
			fwd_pidx_q <= pidx_s1;
			fwd_bim_q  <= bim_new;
			fwd_cho_q  <= cho_new;
			fwd_pat_q  <= pat_new;
		end
	end

	// result
	logic [31:0]             target;
	logic [HB+CTX_IDX_W-1:0] gidx_ext;
	logic [CTX_W-1:0]        ctx_out;

	assign target   = taken ? (pc_s1 + imm_s1) : (pc_s1 + 32'd4);
	assign gidx_ext = {{CTX_IDX_W{1'b0}}, pidx_s1};
	assign ctx_out  = {bpred, gpred, gidx_ext[CTX_IDX_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pred_fire) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pred_fire) out_data_q <= {1'b0, ctx_out, target, taken};
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_axis_tready)
		else $error("transaction accepted during table sweep");

	a_recover_copies: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && act_s1 == ACT_RECOVER) |=> spec_hist_q == $past(commit_hist_q))
		else $error("recover did not restore speculative history");

	a_out_from_predict: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1 && act_s1 == ACT_PREDICT))
		else $error("output transaction not caused by a predict");

endmodule
`default_nettype wire
